FILE: rtl/dasd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasd_pkg: date add/subtract days shared definitions
// Field widths, default sizes, month-length lookup and the leap rule on a
// year residue modulo 400.
// ----------------------------------------------------------------------------
package dasd_pkg;

  localparam int MONTH_BITS       = 4;
  localparam int DAY_BITS         = 5;
  localparam int COUNT_BITS_DEF   = 16;
  localparam int YEAR_BITS_DEF    = 14;
  localparam int LEAP_CYCLE       = 400;
  localparam int RES_BITS         = 9;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_BITS-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_BITS-1:0]   DAY_LAST  = 5'd31;

  typedef logic [RES_BITS-1:0] res_t;

  // Leap year from the year modulo 400: centuries leap only at residue zero
  function automatic logic is_leap(input res_t r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  // Days in a month; any month outside 1..12 falls to the default length of 31
  function automatic logic [DAY_BITS-1:0] days_in(input logic [MONTH_BITS-1:0] m,
                                                  input logic leap);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/date_add_subtract_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_subtract_days: walk a Gregorian date forward and back by N days
// A reciprocal multiply reduces the start year modulo 400, then
// two walkers step one day per cycle in parallel while a counter runs down.
// ----------------------------------------------------------------------------
// Sequence: the year mod 400 reduction, then the walk loop, which steps
//   a day at a time until the counter runs out, then a final walk pass
//   to finish and the done state to strobe.
// Throughput: one transaction at a time; busy stays high until done_o.
// done_o pulses for one cycle; the receiver cannot stall the result.
// Reset: asynchronous, active low; returns to idle with no result pending.
module date_add_subtract_days #(
  parameter int COUNT_BITS = dasd_pkg::COUNT_BITS_DEF,
  parameter int YEAR_BITS  = dasd_pkg::YEAR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [dasd_pkg::MONTH_BITS-1:0] start_month_i,
  input  logic [dasd_pkg::DAY_BITS-1:0]   start_day_i,
  input  logic [YEAR_BITS-1:0]            start_year_i,
  input  logic [COUNT_BITS-1:0]           day_count_i,
  output logic                            done_o,
  output logic [dasd_pkg::MONTH_BITS-1:0] later_month_o,
  output logic [dasd_pkg::DAY_BITS-1:0]   later_day_o,
  output logic [YEAR_BITS-1:0]            later_year_o,
  output logic [dasd_pkg::MONTH_BITS-1:0] earlier_month_o,
  output logic [dasd_pkg::DAY_BITS-1:0]   earlier_day_o,
  output logic [YEAR_BITS-1:0]            earlier_year_o,
  output logic                            year_overflow_o
);

  localparam int MB = dasd_pkg::MONTH_BITS;
  localparam int DB = dasd_pkg::DAY_BITS;
  localparam int RB = dasd_pkg::RES_BITS;
  localparam longint unsigned YEAR_MAX = (64'd1 << YEAR_BITS) - 64'd1;
  localparam dasd_pkg::res_t RES_TOP = RB'(dasd_pkg::LEAP_CYCLE - 1);
  localparam dasd_pkg::res_t RES_YEAR_MAX = RB'(YEAR_MAX % dasd_pkg::LEAP_CYCLE);

  // 400 = 16 * 25: the low four year bits pass through, the rest go mod 25
  localparam int LOW_BITS = 4;
  localparam int ODD_BITS = 5;
  localparam int ODD_DIV  = dasd_pkg::LEAP_CYCLE >> LOW_BITS;
  localparam int XW       = YEAR_BITS - LOW_BITS + 1;
  localparam int SH       = XW + ODD_BITS;
  localparam int PW       = 2 * XW + 10;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(ODD_DIV - 1)) / 64'(ODD_DIV);
  localparam logic [XW:0] RECIP_C = (XW+1)'(RECIP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  wrap_q, wrap_d;

  logic [MB-1:0]         fm_q, fm_d, bm_q, bm_d;
  logic [DB-1:0]         fd_q, fd_d, bd_q, bd_d;
  logic [YEAR_BITS-1:0]  fy_q, fy_d, by_q, by_d;
  dasd_pkg::res_t        fres_q, fres_d, bres_q, bres_d;

  logic [MB-1:0]         m_sat;
  logic [XW-1:0]         year_hi;
  logic [PW-1:0]         recip_prod;
  logic [ODD_BITS-1:0]   quo_lo, rem_odd;
  dasd_pkg::res_t        year_res;
  logic [DB:0]           fd_inc;
  logic [DB-1:0]         f_len, b_len;
  logic [MB-1:0]         bm_dec;

  // Saturate the start month into 1..12
  always_comb begin
    if (start_month_i == '0) begin
      m_sat = dasd_pkg::MONTH_JAN;
    end else if (start_month_i > dasd_pkg::MONTH_DEC) begin
      m_sat = dasd_pkg::MONTH_DEC;
    end else begin
      m_sat = start_month_i;
    end
  end

  // Reduce the start year mod 400 through a reciprocal multiply by 1/25
  assign year_hi    = {1'b0, fy_q[YEAR_BITS-1:LOW_BITS]};
  assign recip_prod = PW'(year_hi) * PW'(RECIP_C);
  assign quo_lo     = recip_prod[SH +: ODD_BITS];
  assign rem_odd    = year_hi[ODD_BITS-1:0] - ODD_BITS'(quo_lo * ODD_BITS'(ODD_DIV));
  assign year_res   = {rem_odd, fy_q[LOW_BITS-1:0]};

  // Month lengths seen by each walker this cycle
  assign fd_inc = {1'b0, fd_q} + (DB+1)'(1);
  assign bm_dec = bm_q - MB'(1);
  assign f_len  = dasd_pkg::days_in(fm_q, dasd_pkg::is_leap(fres_q));
  assign b_len  = dasd_pkg::days_in(bm_dec, dasd_pkg::is_leap(bres_q));

  // Sequence the reduction and the day walk
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    wrap_d   = wrap_q;
    fm_d = fm_q; fd_d = fd_q; fy_d = fy_q; fres_d = fres_q;
    bm_d = bm_q; bd_d = bd_q; by_d = by_q; bres_d = bres_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d  = ST_MOD;
          cnt_d    = day_count_i;
          wrap_d   = 1'b0;
          fm_d = m_sat; fd_d = start_day_i; fy_d = start_year_i; fres_d = '0;
          bm_d = m_sat; bd_d = start_day_i; by_d = start_year_i; bres_d = '0;
        end
      end
      ST_MOD: begin
        fres_d  = year_res;
        bres_d  = year_res;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - COUNT_BITS'(1);
          // Advance the later date
          if (fd_inc <= {1'b0, f_len}) begin
            fd_d = fd_inc[DB-1:0];
          end else if (fm_q < dasd_pkg::MONTH_DEC) begin
            fd_d = dasd_pkg::DAY_FIRST;
            fm_d = fm_q + MB'(1);
          end else begin
            fd_d = dasd_pkg::DAY_FIRST;
            fm_d = dasd_pkg::MONTH_JAN;
            fy_d = fy_q + YEAR_BITS'(1);
            if (fy_q == '1) begin
              wrap_d = 1'b1;
              fres_d = '0;
            end else begin
              fres_d = (fres_q == RES_TOP) ? '0 : fres_q + RB'(1);
            end
          end
          // Step back the earlier date
          if (bd_q >= DB'(2)) begin
            bd_d = bd_q - DB'(1);
          end else if (bm_q > dasd_pkg::MONTH_JAN) begin
            bm_d = bm_dec;
            bd_d = b_len;
          end else begin
            bm_d = dasd_pkg::MONTH_DEC;
            bd_d = dasd_pkg::DAY_LAST;
            by_d = by_q - YEAR_BITS'(1);
            if (by_q == '0) begin
              wrap_d = 1'b1;
              bres_d = RES_YEAR_MAX;
            end else begin
              bres_d = (bres_q == '0) ? RES_TOP : bres_q - RB'(1);
            end
          end
          // Either flag source sets the sticky wrap
          if ((fm_q == dasd_pkg::MONTH_DEC) && (fd_inc > {1'b0, f_len}) && (fy_q == '1)) begin
            wrap_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the working registers
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    wrap_q   <= wrap_d;
    fm_q <= fm_d; fd_q <= fd_d; fy_q <= fy_d; fres_q <= fres_d;
    bm_q <= bm_d; bd_q <= bd_d; by_q <= by_d; bres_q <= bres_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_DONE);
  assign later_month_o   = fm_q;
  assign later_day_o     = fd_q;
  assign later_year_o    = fy_q;
  assign earlier_month_o = bm_q;
  assign earlier_day_o   = bd_q;
  assign earlier_year_o  = by_q;
  assign year_overflow_o = wrap_q;

  // Result strobe is a single pulse and the block then returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !busy && !done_o)
    else $error("done_o not followed by idle");

  // A transaction accepted in idle starts the year reduction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (state_q == ST_MOD))
    else $error("accepted transaction did not enter reduction");

  // The walk ends only once the day counter has run out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_WALK) && ($past(cnt_q) == '0))
    else $error("walk ended with days left");

  // Residues stay below the leap cycle while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (fres_q < 9'd400) && (bres_q < 9'd400))
    else $error("year residue out of range");

endmodule
